// ===== rtl/core/tcr_pkg.sv =====
// shared types and constants for the text console renderer
// no dependencies; imported by every module of the block
package tcr_pkg;

    localparam int DEF_COLUMNS = 160;
    localparam int DEF_ROWS    = 80;

    localparam int COL_W   = 8;
    localparam int ROW_W   = 7;
    localparam int X_W     = 11;
    localparam int Y_W     = 10;
    localparam int CHAR_W  = 8;
    localparam int NUM_W   = 32;
    localparam int COLOR_W = 24;
    localparam int MODE_W  = 3;
    localparam int CMD_W   = 2;

    localparam int NDIGITS = 10;
    localparam int NDIG_W  = 4;
    localparam int CONV_STEPS = 8;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'd10;
    localparam logic [COLOR_W-1:0] COLOR_RESET  = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] COLOR_BLACK  = 24'h000000;

    typedef enum logic [MODE_W-1:0] {
        MODE_CHAR  = 3'd0,
        MODE_DEC   = 3'd1,
        MODE_HEX   = 3'd2,
        MODE_ERASE = 3'd3,
        MODE_CLEAR = 3'd4
    } mode_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_GLYPH = 2'd0,
        CMD_ERASE = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        OP_GLYPH,
        OP_NEWLINE,
        OP_DIGITS,
        OP_ERASE,
        OP_CLEAR
    } op_kind_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_CONV,
        FE_PUSH
    } fe_state_t;

    typedef enum logic {
        BE_IDLE,
        BE_RUN
    } be_state_t;

    typedef logic [NDIGITS-1:0][3:0] digits_t;

    typedef struct packed {
        op_kind_t             kind;
        logic [CHAR_W-1:0]    ch;
        digits_t              digits;
        logic [NDIG_W-1:0]    ndig;
    } op_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

endpackage

// ===== rtl/core/text_console_renderer_core.sv =====
// top level of the text console renderer: color register, front end, queue, back end
// depends on tcr_pkg, tcr_front, tcr_queue, tcr_back
//
// input channel: in_valid / in_stall with mode, character, number. one word is
// one console operation: print a character (newline moves the cursor only),
// print a number in decimal or hex, erase the previous cell or clear the screen.
// output channel: out_valid / out_stall with command, pixel_x, pixel_y, glyph,
// color, last. each operation gives zero to ten draw words, last set on the final.
// cfg_wr_en / cfg_wr_data write the 24-bit glyph color; the user must write it only
// when the block is idle, the block does not enforce this. a character word passes
// the queue, the back end's operation register and the output register; a decimal
// number first takes the 8-step bcd conversion in the front. the back end gives one
// draw word per cycle within an operation while the output is not stalled; the
// decimal converter blocks new input until its digits are pushed, other words are
// taken each cycle while the 2-entry queue has room. a stalled output holds its word
// and the back end waits; the queue then fills and in_stall rises. reset clears the
// cursor, the queue and the output valid and sets the glyph color to white.
module text_console_renderer_core
#(
    parameter int COLUMNS = tcr_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcr_pkg::DEF_ROWS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tcr_pkg::COLOR_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tcr_pkg::MODE_W-1:0]    mode,
    input  logic [tcr_pkg::CHAR_W-1:0]    character,
    input  logic [tcr_pkg::NUM_W-1:0]     number,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tcr_pkg::CMD_W-1:0]     command,
    output logic [tcr_pkg::X_W-1:0]       pixel_x,
    output logic [tcr_pkg::Y_W-1:0]       pixel_y,
    output logic [tcr_pkg::CHAR_W-1:0]    glyph,
    output logic [tcr_pkg::COLOR_W-1:0]   color,
    output logic                          last
);
    import tcr_pkg::*;

    logic [COLOR_W-1:0] text_color_reg;
    q_status_t          q_status;
    logic               push;
    op_t                push_op;
    logic               pop;
    op_t                pop_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= COLOR_RESET;
        end
        else if (cfg_wr_en)
        begin
            text_color_reg <= cfg_wr_data;
        end
    end

    tcr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .character (character),
        .number    (number),
        .q_status  (q_status),
        .push      (push),
        .push_op   (push_op)
    );

    tcr_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .pop_op  (pop_op),
        .status  (q_status)
    );

    tcr_back
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_op     (pop_op),
        .pop        (pop),
        .text_color (text_color_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .command    (command),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .glyph      (glyph),
        .color      (color),
        .last       (last)
    );

endmodule

// ===== rtl/core/tcr_queue.sv =====
// two-entry operation queue between front and back
// depends on tcr_pkg
module tcr_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tcr_pkg::op_t  push_op,
    input  logic          pop,
    output tcr_pkg::op_t  pop_op,
    output tcr_pkg::q_status_t status
);
    import tcr_pkg::*;

    op_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.valid = (count_reg != '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && status.valid;
    assign pop_op  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/tcr_front.sv =====
// front end: accepts input words, classifies them and converts numbers to digits
// depends on tcr_pkg; feeds tcr_queue
module tcr_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tcr_pkg::MODE_W-1:0]    mode,
    input  logic [tcr_pkg::CHAR_W-1:0]    character,
    input  logic [tcr_pkg::NUM_W-1:0]     number,
    input  tcr_pkg::q_status_t            q_status,
    output logic                          push,
    output tcr_pkg::op_t                  push_op
);
    import tcr_pkg::*;

    localparam int SH_W = 4 * NDIGITS + NUM_W;

    fe_state_t       state_reg;
    fe_state_t       state_next;
    logic [SH_W-1:0] shift_reg;
    logic [SH_W-1:0] shift_next;
    logic [2:0]      step_reg;
    logic [2:0]      step_next;
    logic            accept;
    digits_t         hex_digits;

    // four shift-and-adjust steps of the binary to bcd conversion
    function automatic logic [SH_W-1:0] dabble4(input logic [SH_W-1:0] v);
        logic [SH_W-1:0] t;
        t = v;
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < NDIGITS; j++)
            begin
                if (t[NUM_W+4*j +: 4] >= 4'd5)
                begin
                    t[NUM_W+4*j +: 4] = t[NUM_W+4*j +: 4] + 4'd3;
                end
            end
            t = t << 1;
        end
        return t;
    endfunction

    function automatic logic [NDIG_W-1:0] digit_count(input digits_t d);
        logic [NDIG_W-1:0] n;
        n = NDIG_W'(1);
        for (int i = 0; i < NDIGITS; i++)
        begin
            if (d[i] != 4'd0)
            begin
                n = NDIG_W'(i + 1);
            end
        end
        return n;
    endfunction

    assign in_stall   = (state_reg != FE_IDLE) || q_status.full;
    assign accept     = in_valid && !in_stall;
    assign hex_digits = digits_t'({{(4*NDIGITS-NUM_W){1'b0}}, number});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        shift_next     = shift_reg;
        push           = 1'b0;
        push_op.kind   = OP_GLYPH;
        push_op.ch     = character;
        push_op.digits = hex_digits;
        push_op.ndig   = digit_count(hex_digits);
        case (state_reg)
            FE_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_CHAR:
                        begin
                            push         = 1'b1;
                            push_op.kind = (character == NEWLINE_CHAR) ? OP_NEWLINE : OP_GLYPH;
                        end
                        MODE_DEC:
                        begin
                            shift_next = {{(4*NDIGITS){1'b0}}, number};
                            step_next  = '0;
                            state_next = FE_CONV;
                        end
                        MODE_HEX:
                        begin
                            push         = 1'b1;
                            push_op.kind = OP_DIGITS;
                        end
                        MODE_ERASE:
                        begin
                            push         = 1'b1;
                            push_op.kind = OP_ERASE;
                        end
                        MODE_CLEAR:
                        begin
                            push         = 1'b1;
                            push_op.kind = OP_CLEAR;
                        end
                        default:
                        begin
                            push = 1'b0;
                        end
                    endcase
                end
            end
            FE_CONV:
            begin
                shift_next = dabble4(shift_reg);
                step_next  = step_reg + 1'b1;
                if (step_reg == 3'(CONV_STEPS - 1))
                begin
                    state_next = FE_PUSH;
                end
            end
            FE_PUSH:
            begin
                push_op.kind   = OP_DIGITS;
                push_op.digits = digits_t'(shift_reg[SH_W-1:NUM_W]);
                push_op.ndig   = digit_count(digits_t'(shift_reg[SH_W-1:NUM_W]));
                if (!q_status.full)
                begin
                    push       = 1'b1;
                    state_next = FE_IDLE;
                end
            end
            default:
            begin
                state_next = FE_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/tcr_back.sv =====
// back end: cursor tracking and draw word generation with an output register
// depends on tcr_pkg; drains tcr_queue
module tcr_back
#(
    parameter int COLUMNS = tcr_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcr_pkg::DEF_ROWS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcr_pkg::q_status_t            q_status,
    input  tcr_pkg::op_t                  pop_op,
    output logic                          pop,
    input  logic [tcr_pkg::COLOR_W-1:0]   text_color,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tcr_pkg::CMD_W-1:0]     command,
    output logic [tcr_pkg::X_W-1:0]       pixel_x,
    output logic [tcr_pkg::Y_W-1:0]       pixel_y,
    output logic [tcr_pkg::CHAR_W-1:0]    glyph,
    output logic [tcr_pkg::COLOR_W-1:0]   color,
    output logic                          last
);
    import tcr_pkg::*;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    be_state_t          state_reg;
    be_state_t          state_next;
    op_t                cur_reg;
    op_t                cur_next;
    logic [NDIG_W-1:0]  idx_reg;
    logic [NDIG_W-1:0]  idx_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;
    logic [X_W-1:0]     x_reg;
    logic [X_W-1:0]     x_next;
    logic [Y_W-1:0]     y_reg;
    logic [Y_W-1:0]     y_next;
    logic [CHAR_W-1:0]  glyph_reg;
    logic [CHAR_W-1:0]  glyph_next;
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;
    logic               last_reg;
    logic               last_next;

    logic               out_free;
    logic [ROW_W-1:0]   row_inc;
    logic [ROW_W-1:0]   row_dec;
    logic [COL_W-1:0]   col_dec;
    logic [3:0]         cur_digit;
    logic [CHAR_W-1:0]  digit_char;
    logic               final_word;

    function automatic logic [X_W-1:0] xpos(input logic [COL_W-1:0] c);
        return {c, 3'b000};
    endfunction

    function automatic logic [Y_W-1:0] ypos(input logic [ROW_W-1:0] r);
        logic [ROW_W+3:0] y;
        y = {r, 3'b000} + {1'b0, r, 2'b00};
        return y[Y_W-1:0];
    endfunction

    assign out_free   = !out_valid_reg || !out_stall;
    assign row_inc    = (row_reg == LAST_ROW) ? '0 : row_reg + 1'b1;
    assign row_dec    = (row_reg == '0) ? LAST_ROW : row_reg - 1'b1;
    assign col_dec    = (col_reg == '0) ? LAST_COL : col_reg - 1'b1;
    assign cur_digit  = cur_reg.digits[idx_reg];
    assign digit_char = (cur_digit < 4'd10) ? (8'h30 + CHAR_W'(cur_digit))
                                            : (8'd55 + CHAR_W'(cur_digit));
    assign final_word = (cur_reg.kind != OP_DIGITS) || (idx_reg == '0);

    assign out_valid = out_valid_reg;
    assign command   = cmd_reg;
    assign pixel_x   = x_reg;
    assign pixel_y   = y_reg;
    assign glyph     = glyph_reg;
    assign color     = color_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BE_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        idx_reg   <= idx_next;
        cmd_reg   <= cmd_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        glyph_reg <= glyph_next;
        color_reg <= color_next;
        last_reg  <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd_next       = cmd_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        glyph_next     = glyph_reg;
        color_next     = color_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        case (state_reg)
            BE_IDLE:
            begin
                if (q_status.valid)
                begin
                    pop        = 1'b1;
                    cur_next   = pop_op;
                    idx_next   = pop_op.ndig - 1'b1;
                    state_next = BE_RUN;
                end
            end
            BE_RUN:
            begin
                case (cur_reg.kind)
                    OP_NEWLINE:
                    begin
                        col_next   = '0;
                        row_next   = row_inc;
                        state_next = BE_IDLE;
                    end
                    OP_GLYPH, OP_DIGITS:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            cmd_next       = CMD_GLYPH;
                            x_next         = xpos(col_reg);
                            y_next         = ypos(row_reg);
                            glyph_next     = (cur_reg.kind == OP_GLYPH) ? cur_reg.ch : digit_char;
                            color_next     = text_color;
                            last_next      = final_word;
                            if (col_reg == LAST_COL)
                            begin
                                col_next = '0;
                                row_next = row_inc;
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                            if (final_word)
                            begin
                                state_next = BE_IDLE;
                            end
                            else
                            begin
                                idx_next = idx_reg - 1'b1;
                            end
                        end
                    end
                    OP_ERASE:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            cmd_next       = CMD_ERASE;
                            x_next         = xpos(col_dec);
                            y_next         = ypos((col_reg == '0) ? row_dec : row_reg);
                            glyph_next     = '0;
                            color_next     = COLOR_BLACK;
                            last_next      = 1'b1;
                            col_next       = col_dec;
                            row_next       = (col_reg == '0) ? row_dec : row_reg;
                            state_next     = BE_IDLE;
                        end
                    end
                    OP_CLEAR:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            cmd_next       = CMD_CLEAR;
                            x_next         = '0;
                            y_next         = '0;
                            glyph_next     = '0;
                            color_next     = COLOR_BLACK;
                            last_next      = 1'b1;
                            col_next       = '0;
                            row_next       = '0;
                            state_next     = BE_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = BE_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = BE_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < COLUMNS)
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) < ROWS)
        else $error("cursor row out of range");

    a_black_non_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (cmd_reg != CMD_GLYPH) |-> (color_reg == COLOR_BLACK) && last_reg)
        else $error("erase or clear word with color or without last");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == BE_IDLE) && q_status.valid)
        else $error("queue popped while busy or empty");
`endif

endmodule
